/* hw/rtl/hdbu_pkg.sv */
// shared types and constants for the half-duplex bit uart
package hdbu_pkg;

   // item action codes
   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_SEND = 2'd1,
      ACT_RECV = 2'd2,
      ACT_TAKE = 2'd3
   } action_type;

   localparam int DATA_W       = 8;
   localparam int FRAME_W      = DATA_W + 2;
   localparam int BITS_LEFT_W  = 4;

   localparam logic [BITS_LEFT_W-1:0] FRAME_BITS = 4'hA;
   localparam logic [DATA_W-1:0]      FIRST_MASK = 8'h01;
   localparam logic                   LINE_MARK  = 1'b1;
   localparam logic                   LINE_SPACE = 1'b0;

   // one input beat
   typedef struct packed {
      action_type        action;
      logic [DATA_W-1:0] tx_data;
      logic              rx_level;
   } item_type;

   // one result beat
   typedef struct packed {
      logic              tx_line;
      logic              tx_busy;
      logic              rx_busy;
      logic              data_ready;
      logic [DATA_W-1:0] rx_data;
   } result_type;

   // internal counters seen by the top level checks
   typedef struct packed {
      logic [BITS_LEFT_W-1:0] tx_bits_left;
      logic [DATA_W-1:0]      rx_bit_mask;
   } status_type;

endpackage

/* hw/rtl/hdbu_in_stage.sv */
// input register stage holding one request beat
module hdbu_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_tx_data,
   input  logic                   req_rx_level,
   output logic                   req_stall,
   input  logic                   item_take,
   output logic                   item_valid,
   output hdbu_pkg::item_type     item
);
   import hdbu_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // hold off the sender only while a held beat cannot move on
   assign req_stall = valid_ff && !item_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = (valid_ff && !item_take) || load;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.action   <= action_type'(req_action);
         item_ff.tx_data  <= req_tx_data;
         item_ff.rx_level <= req_rx_level;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hw/rtl/hdbu_engine.sv */
// uart state registers and the single-pass update for one item
module hdbu_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  hdbu_pkg::item_type     item,
   output hdbu_pkg::result_type   result,
   output hdbu_pkg::status_type   status
);
   import hdbu_pkg::*;

   logic [FRAME_W-1:0]     tx_shift_ff,     tx_shift_in;
   logic [BITS_LEFT_W-1:0] tx_bits_left_ff, tx_bits_left_in;
   logic                   tx_active_ff,    tx_active_in;
   logic                   line_level_ff,   line_level_in;
   logic [DATA_W-1:0]      rx_shift_ff,     rx_shift_in;
   logic [DATA_W-1:0]      rx_bit_mask_ff,  rx_bit_mask_in;
   logic                   rx_active_ff,    rx_active_in;
   logic                   byte_ready_ff,   byte_ready_in;

   // next state for the item in hand
   always_comb begin
      tx_shift_in     = tx_shift_ff;
      tx_bits_left_in = tx_bits_left_ff;
      tx_active_in    = tx_active_ff;
      line_level_in   = line_level_ff;
      rx_shift_in     = rx_shift_ff;
      rx_bit_mask_in  = rx_bit_mask_ff;
      rx_active_in    = rx_active_ff;
      byte_ready_in   = byte_ready_ff;
      case (item.action)
         ACT_TICK: begin
            // reception owns the tick, transmit waits
            if (rx_active_ff) begin
               if (item.rx_level) begin
                  rx_shift_in = rx_shift_ff | rx_bit_mask_ff;
               end else begin
                  rx_shift_in = rx_shift_ff & ~rx_bit_mask_ff;
               end
               if (rx_bit_mask_ff[DATA_W-1]) begin
                  rx_active_in  = 1'b0;
                  byte_ready_in = 1'b1;
               end else begin
                  rx_bit_mask_in = {rx_bit_mask_ff[DATA_W-2:0], 1'b0};
               end
            end else if (tx_active_ff) begin
               if (tx_bits_left_ff == '0) begin
                  tx_active_in = 1'b0;
               end else begin
                  line_level_in   = tx_shift_ff[0];
                  tx_shift_in     = {1'b0, tx_shift_ff[FRAME_W-1:1]};
                  tx_bits_left_in = tx_bits_left_ff - 1'b1;
               end
            end
         end
         ACT_SEND: begin
            // stop bit, data lsb first, start bit
            if (!tx_active_ff) begin
               tx_bits_left_in = FRAME_BITS;
               tx_shift_in     = {LINE_MARK, item.tx_data, LINE_SPACE};
               tx_active_in    = 1'b1;
            end
         end
         ACT_RECV: begin
            if (!tx_active_ff) begin
               rx_active_in   = 1'b1;
               rx_shift_in    = '0;
               rx_bit_mask_in = FIRST_MASK;
            end
         end
         default: begin
            byte_ready_in = 1'b0;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff     <= '0;
         tx_bits_left_ff <= '0;
         tx_active_ff    <= 1'b0;
         line_level_ff   <= LINE_MARK;
         rx_shift_ff     <= '0;
         rx_bit_mask_ff  <= FIRST_MASK;
         rx_active_ff    <= 1'b0;
         byte_ready_ff   <= 1'b0;
      end else if (advance) begin
         tx_shift_ff     <= tx_shift_in;
         tx_bits_left_ff <= tx_bits_left_in;
         tx_active_ff    <= tx_active_in;
         line_level_ff   <= line_level_in;
         rx_shift_ff     <= rx_shift_in;
         rx_bit_mask_ff  <= rx_bit_mask_in;
         rx_active_ff    <= rx_active_in;
         byte_ready_ff   <= byte_ready_in;
      end
   end

   // result shows the state after the item
   assign result.tx_line    = line_level_in;
   assign result.tx_busy    = tx_active_in;
   assign result.rx_busy    = rx_active_in;
   assign result.data_ready = byte_ready_in;
   assign result.rx_data    = rx_shift_in;

   assign status.tx_bits_left = tx_bits_left_ff;
   assign status.rx_bit_mask  = rx_bit_mask_ff;

endmodule

/* hw/rtl/hdbu_out_stage.sv */
// result register driving the response channel
module hdbu_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  hdbu_pkg::result_type   result,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_tx_line,
   output logic                   rsp_tx_busy,
   output logic                   rsp_rx_busy,
   output logic                   rsp_data_ready,
   output logic [7:0]             rsp_rx_data
);
   import hdbu_pkg::*;

   logic       valid_ff;
   result_type result_ff;
   logic       load;

   // the register takes a new beat when empty or being drained
   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = item_valid && out_ready;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= item_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_tx_line    = result_ff.tx_line;
   assign rsp_tx_busy    = result_ff.tx_busy;
   assign rsp_rx_busy    = result_ff.rx_busy;
   assign rsp_data_ready = result_ff.data_ready;
   assign rsp_rx_data    = result_ff.rx_data;

endmodule

/* hw/rtl/half_duplex_bit_uart_core.sv */
// half-duplex 8n1 uart stepped by bit-tick beats, top level
// an accepted request beat passes the request register, then the result register, on its way to the response beat
// throughput: one beat per cycle while rsp_stall is low, as the state update is combinational
// while a response waits, the request register takes one more beat if it is empty, then stalls
// reset: synchronous active high, empties both stages, line idles at mark
module half_duplex_bit_uart_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_tx_data,
   input  logic       req_rx_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_line,
   output logic       rsp_tx_busy,
   output logic       rsp_rx_busy,
   output logic       rsp_data_ready,
   output logic [7:0] rsp_rx_data
);
   import hdbu_pkg::*;

   item_type   item;
   logic       item_valid;
   logic       out_ready;
   logic       advance;
   result_type result;
   status_type status;

   assign advance = item_valid && out_ready;

   // request register
   hdbu_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_action   (req_action),
      .req_tx_data  (req_tx_data),
      .req_rx_level (req_rx_level),
      .req_stall    (req_stall),
      .item_take    (out_ready),
      .item_valid   (item_valid),
      .item         (item)
   );

   // uart state and update
   hdbu_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result),
      .status  (status)
   );

   // result register
   hdbu_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .result         (result),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_line    (rsp_tx_line),
      .rsp_tx_busy    (rsp_tx_busy),
      .rsp_rx_busy    (rsp_rx_busy),
      .rsp_data_ready (rsp_data_ready),
      .rsp_rx_data    (rsp_rx_data)
   );

   // receive bit mask always marks exactly one bit
   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(status.rx_bit_mask))
      else $error("rx bit mask not one-hot");

   // frame counter never exceeds one frame
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      status.tx_bits_left <= FRAME_BITS)
      else $error("tx bit count out of range");

   // a held request beat reaches the result register when it is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("request beat not forwarded");

   // stall toward the sender only while the request register is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid)
      else $error("stall with empty request register");

endmodule

/* dv/half_duplex_bit_uart_core_test.sv */
// testbench for the half-duplex bit uart core: directed table, then random frames
module half_duplex_bit_uart_core_test;
   import hdbu_pkg::*;

   localparam int RANDOM_BEATS = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;
   localparam int SETTLE_WAIT  = 10;

   typedef enum int {
      STALL_NONE,
      STALL_SPARSE,
      STALL_RUNS
   } stall_mode_type;

   // one row of the directed table
   typedef struct {
      action_type act;
      logic [7:0] data;
      logic       lvl;
      bit         typed;
      result_type status;
   } row_type;

   logic       clock;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [1:0] req_action   = ACT_TICK;
   logic [7:0] req_tx_data  = 8'h00;
   logic       req_rx_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic       rsp_tx_line;
   logic       rsp_tx_busy;
   logic       rsp_rx_busy;
   logic       rsp_data_ready;
   logic [7:0] rsp_rx_data;

   // typed-in expectation travelling with the current request beat
   bit         beat_typed  = 1'b0;
   result_type beat_status = '0;

   row_type    plan_q[$];
   result_type status_due_q[$];
   int         beats_sent  = 0;
   int         burst_left  = 0;
   int         rsp_count   = 0;
   int         fault_count = 0;
   int         idle_cycles = 0;

   // predicted uart state
   logic [FRAME_W-1:0]     frame_sr;
   logic [BITS_LEFT_W-1:0] frame_left;
   logic                   frame_on;
   logic                   line_now;
   logic [DATA_W-1:0]      rx_sr;
   logic [DATA_W-1:0]      rx_mask;
   logic                   rx_on;
   logic                   byte_held;

   // response stall pattern state
   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_window = 0;
   int             stall_run    = 0;
   logic           stall_hold   = 1'b0;

   half_duplex_bit_uart_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_tx_data    (req_tx_data),
      .req_rx_level   (req_rx_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_line    (rsp_tx_line),
      .rsp_tx_busy    (rsp_tx_busy),
      .rsp_rx_busy    (rsp_rx_busy),
      .rsp_data_ready (rsp_data_ready),
      .rsp_rx_data    (rsp_rx_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // apply one beat to the predicted state and return the status after it
   function automatic result_type uart_after_beat(item_type beat);
      case (beat.action)
         ACT_TICK: begin
            // reception owns the tick, a pending frame waits
            if (rx_on) begin
               rx_sr = beat.rx_level ? (rx_sr | rx_mask) : (rx_sr & ~rx_mask);
               if (rx_mask[DATA_W-1]) begin
                  rx_on     = 1'b0;
                  byte_held = 1'b1;
               end else begin
                  rx_mask = rx_mask << 1;
               end
            end else if (frame_on) begin
               if (frame_left == '0) begin
                  frame_on = 1'b0;
               end else begin
                  line_now   = frame_sr[0];
                  frame_sr   = frame_sr >> 1;
                  frame_left = frame_left - 1'b1;
               end
            end
         end
         ACT_SEND: begin
            if (!frame_on) begin
               frame_left = FRAME_BITS;
               frame_sr   = {LINE_MARK, beat.tx_data, LINE_SPACE};
               frame_on   = 1'b1;
            end
         end
         ACT_RECV: begin
            if (!frame_on) begin
               rx_on   = 1'b1;
               rx_sr   = '0;
               rx_mask = FIRST_MASK;
            end
         end
         default: begin
            byte_held = 1'b0;
         end
      endcase
      return {line_now, frame_on, rx_on, byte_held, rx_sr};
   endfunction

   // drive one request beat at the falling edge, after a random idle gap between bursts, wait for its acceptance
   task automatic drive_beat(action_type act, logic [7:0] data, logic lvl, bit typed,
                             result_type status);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_tx_data  <= data;
      req_rx_level <= lvl;
      beat_typed   <= typed;
      beat_status  <= status;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      beats_sent++;
   endtask

   task automatic drive_random(action_type act);
      drive_beat(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   task automatic add_row(action_type act, logic [7:0] data, logic lvl, bit typed,
                          result_type status);
      row_type r;
      r.act    = act;
      r.data   = data;
      r.lvl    = lvl;
      r.typed  = typed;
      r.status = status;
      plan_q.push_back(r);
   endtask

   // random part: mostly whole frames and received bytes, some noise
   task automatic run_random;
      int kind;
      int n;
      int send_at;
      while (beats_sent < plan_q.size() + RANDOM_BEATS) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // full transmit frame with the clearing tick
            drive_random(ACT_SEND);
            for (n = 0; n < FRAME_W + 1; n++) begin
               if ($urandom_range(0, 15) == 0) drive_random(ACT_TAKE);
               drive_random(ACT_TICK);
            end
         end else if (kind < 8) begin
            // receive a byte, now and then with a send queued behind it
            send_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, DATA_W - 1) : -1;
            drive_random(ACT_RECV);
            for (n = 0; n < DATA_W; n++) begin
               if (n == send_at) drive_random(ACT_SEND);
               if ($urandom_range(0, 23) == 0) drive_random(ACT_RECV);
               drive_random(ACT_TICK);
            end
            if ($urandom_range(0, 3) != 0) drive_random(ACT_TAKE);
            if (send_at >= 0) begin
               for (n = 0; n < FRAME_W + 1; n++) drive_random(ACT_TICK);
            end
         end else begin
            // loose beats of any kind
            repeat ($urandom_range(1, 6)) drive_random(action_type'($urandom_range(0, 3)));
         end
      end
   endtask

   // response stall pattern: quiet windows, sparse stalls, long runs
   always @(negedge clock) begin
      if (stall_window == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 2));
         stall_window = $urandom_range(16, 96);
      end
      stall_window--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_SPARSE: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            if (stall_run == 0) begin
               stall_run  = $urandom_range(1, 6);
               stall_hold = ~stall_hold;
            end
            stall_run--;
            rsp_stall <= stall_hold;
         end
      endcase
   end

   // check response beats, then predict for the accepted request beat
   always @(posedge clock) begin : monitor
      item_type   beat;
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tx_line, rsp_tx_busy, rsp_rx_busy, rsp_data_ready, rsp_rx_data};
            if (status_due_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("response beat %0d arrived with nothing outstanding: %h",
                           rsp_count, got);
            end else begin
               want = status_due_q.pop_front();
               if (got.tx_line !== want.tx_line || got.tx_busy !== want.tx_busy ||
                   got.rx_busy !== want.rx_busy || got.data_ready !== want.data_ready ||
                   got.rx_data !== want.rx_data) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX)
                     $display("beat %0d: expected line %b txb %b rxb %b rdy %b data %h, %s",
                              rsp_count, want.tx_line, want.tx_busy, want.rx_busy,
                              want.data_ready, want.rx_data, "mismatch");
                  if (fault_count <= REPORT_MAX)
                     $display("beat %0d:      got line %b txb %b rxb %b rdy %b data %h",
                              rsp_count, got.tx_line, got.tx_busy, got.rx_busy,
                              got.data_ready, got.rx_data);
               end
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            beat.action   = action_type'(req_action);
            beat.tx_data  = req_tx_data;
            beat.rx_level = req_rx_level;
            want = uart_after_beat(beat);
            if (beat_typed) want = beat_status;
            status_due_q.push_back(want);
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // predicted state after reset
      frame_sr   = '0;
      frame_left = '0;
      frame_on   = 1'b0;
      line_now   = LINE_MARK;
      rx_sr      = '0;
      rx_mask    = FIRST_MASK;
      rx_on      = 1'b0;
      byte_held  = 1'b0;

      // idle corner cases
      add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, {LINE_MARK, 1'b0, 1'b0, 1'b0, 8'h00});
      add_row(ACT_TAKE, 8'hFF, 1'b1, 1'b1, {LINE_MARK, 1'b0, 1'b0, 1'b0, 8'h00});
      // receive, restart mid byte, then queue a send behind reception
      add_row(ACT_RECV, 8'h00, 1'b0, 1'b1, {LINE_MARK, 1'b0, 1'b1, 1'b0, 8'h00});
      add_row(ACT_TICK, 8'h00, 1'b1, 1'b1, {LINE_MARK, 1'b0, 1'b1, 1'b0, 8'h01});
      add_row(ACT_RECV, 8'h00, 1'b0, 1'b1, {LINE_MARK, 1'b0, 1'b1, 1'b0, 8'h00});
      add_row(ACT_SEND, 8'h00, 1'b0, 1'b1, {LINE_MARK, 1'b1, 1'b1, 1'b0, 8'h00});
      repeat (DATA_W - 1) add_row(ACT_TICK, 8'h00, 1'b1, 1'b0, '0);
      add_row(ACT_TICK, 8'h00, 1'b1, 1'b1, {LINE_MARK, 1'b1, 1'b0, 1'b1, 8'hFF});
      // queued frame starts with its start bit, take and ignored requests
      add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, {LINE_SPACE, 1'b1, 1'b0, 1'b1, 8'hFF});
      add_row(ACT_TAKE, 8'h00, 1'b0, 1'b1, {LINE_SPACE, 1'b1, 1'b0, 1'b0, 8'hFF});
      add_row(ACT_SEND, 8'hFF, 1'b1, 1'b1, {LINE_SPACE, 1'b1, 1'b0, 1'b0, 8'hFF});
      add_row(ACT_RECV, 8'hFF, 1'b1, 1'b1, {LINE_SPACE, 1'b1, 1'b0, 1'b0, 8'hFF});
      repeat (7) add_row(ACT_TICK, 8'hFF, 1'b0, 1'b0, '0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan_q[i])
         drive_beat(plan_q[i].act, plan_q[i].data, plan_q[i].lvl, plan_q[i].typed,
                    plan_q[i].status);
      run_random();
      req_valid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (fault_count == 0 && status_due_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* half_duplex_bit_uart_core.f */
hw/rtl/hdbu_pkg.sv
hw/rtl/hdbu_in_stage.sv
hw/rtl/hdbu_engine.sv
hw/rtl/hdbu_out_stage.sv
hw/rtl/half_duplex_bit_uart_core.sv
dv/half_duplex_bit_uart_core_test.sv
